>>> sv/lbcs_pkg.sv
// Shared widths, command codes and reset values of the LED blink-code sequencer.
package lbcs_pkg;

  // Field widths of the request and result items and of the tick rate.
  localparam int unsigned CMD_W   = 1;
  localparam int unsigned IDX_W   = 1;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned OUT_W   = 2;
  localparam int unsigned TPS_W   = 16;

  // Request codes carried in the cmd field.
  localparam logic [CMD_W-1:0] CMD_TICK = 1'b0;
  localparam logic [CMD_W-1:0] CMD_SET  = 1'b1;

  // Reset value of the ticks-per-second register.
  localparam logic [TPS_W-1:0] TPS_RESET = 16'd100;

endpackage

>>> sv/lbcs_in_if.sv
// Request channel of the LED blink-code sequencer: valid, ready and the request payload.
interface lbcs_in_if;
  logic                              valid;
  logic                              ready;
  logic [lbcs_pkg::CMD_W-1:0]        cmd;
  logic [lbcs_pkg::IDX_W-1:0]        led_index;
  logic [lbcs_pkg::COUNT_W-1:0]      blink_count;

  modport source (output valid, output cmd, output led_index, output blink_count,
                  input ready);
  modport sink   (input valid, input cmd, input led_index, input blink_count,
                  output ready);
endinterface

>>> sv/lbcs_out_if.sv
// Result channel of the LED blink-code sequencer: valid, ready and the level and busy masks.
interface lbcs_out_if;
  logic                         valid;
  logic                         ready;
  logic [lbcs_pkg::OUT_W-1:0]   led_levels;
  logic [lbcs_pkg::OUT_W-1:0]   busy_mask;

  modport source (output valid, output led_levels, output busy_mask, input ready);
  modport sink   (input valid, input led_levels, input busy_mask, output ready);
endinterface

>>> sv/led_blink_code_sequencer_core.sv
// LED blink-code sequencer: per-LED blink sequence state and the registered result stage.
//
// Usage: each request on in_ch is either a time tick (cmd = tick) or a set command
// that loads a blink count for the LED at led_index and arms its sequence. An armed
// LED goes dark for one second, lights for one second, goes dark for one second,
// then shows blink_count pulses of a quarter second lit and a quarter second dark.
// A count of zero stops the sequence and leaves the LED level as it is. Set commands
// with led_index >= LED_COUNT change nothing.
// Every request yields exactly one result on out_ch with the LED levels and busy flags
// after that request. The result is registered: it appears in the cycle after the
// request is taken. One request is taken per cycle while the result register is
// empty or being emptied in the same cycle; the per-LED update is one short step of
// logic between the state registers. A stalled receiver holds the result and stalls
// in_ch until it is taken.
// cfg_we with cfg_wdata writes ticks_per_second; it only affects waits loaded later.
// Reset (rst_n low, synchronous) clears all sequences, empties the result register
// and sets ticks_per_second to 100.
module led_blink_code_sequencer_core #(
  parameter int unsigned LED_COUNT = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lbcs_pkg::TPS_W-1:0]  cfg_wdata,
  lbcs_in_if.sink                     in_ch,
  lbcs_out_if.source                  out_ch
);

  localparam int unsigned PadW = (LED_COUNT > lbcs_pkg::OUT_W) ? LED_COUNT : lbcs_pkg::OUT_W;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SILENT = 3'd1,
    PH_FIRST  = 3'd2,
    PH_BDARK  = 3'd3,
    PH_BLIT   = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  logic [lbcs_pkg::TPS_W-1:0] tps_r;
  logic [lbcs_pkg::TPS_W-1:0] quarter;
  logic                       accept;
  logic                       is_tick;
  logic                       set_ok;
  logic [LED_COUNT-1:0]       lit_r;
  logic [LED_COUNT-1:0]       active_r;
  logic [LED_COUNT-1:0]       lit_nxt;
  logic [LED_COUNT-1:0]       active_nxt;
  logic [PadW-1:0]            lit_pad;
  logic [PadW-1:0]            active_pad;
  logic                       out_valid_r;
  logic [lbcs_pkg::OUT_W-1:0] levels_r;
  logic [lbcs_pkg::OUT_W-1:0] busy_r;

  // Request handshake: take a request whenever the result register is free this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_tick     = (in_ch.cmd == lbcs_pkg::CMD_TICK);
  assign set_ok      = (in_ch.cmd == lbcs_pkg::CMD_SET) &&
                       (32'(in_ch.led_index) < LED_COUNT);
  assign quarter     = tps_r >> 2;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= lbcs_pkg::TPS_RESET;
    end else if (cfg_we) begin
      tps_r <= cfg_wdata;
    end
  end

  // One sequencer per LED.
  for (genvar g = 0; g < LED_COUNT; g++) begin : g_led
    phase_t                       phase_r, phase_nxt;
    logic [lbcs_pkg::TPS_W-1:0]   wait_r, wait_nxt;
    logic [lbcs_pkg::COUNT_W-1:0] pulses_r, pulses_nxt;
    logic [lbcs_pkg::COUNT_W-1:0] code_r, code_nxt;
    logic                         hit;

    assign hit = set_ok && (32'(in_ch.led_index) == g);

    // Next state: a set command restarts, a tick counts down or steps the sequence.
    always_comb begin
      phase_nxt     = phase_r;
      wait_nxt      = wait_r;
      pulses_nxt    = pulses_r;
      code_nxt      = code_r;
      lit_nxt[g]    = lit_r[g];
      active_nxt[g] = active_r[g];
      if (accept && hit) begin
        code_nxt      = in_ch.blink_count;
        phase_nxt     = PH_START;
        wait_nxt      = '0;
        active_nxt[g] = (in_ch.blink_count != '0);
      end else if (accept && is_tick && active_r[g]) begin
        if (wait_r > lbcs_pkg::TPS_W'(1)) begin
          wait_nxt = wait_r - lbcs_pkg::TPS_W'(1);
        end else begin
          case (phase_r)
            PH_START: begin
              lit_nxt[g] = 1'b0;
              phase_nxt  = PH_SILENT;
              wait_nxt   = tps_r;
              pulses_nxt = code_r;
            end
            PH_SILENT: begin
              lit_nxt[g] = 1'b1;
              phase_nxt  = PH_FIRST;
              wait_nxt   = tps_r;
            end
            PH_FIRST: begin
              lit_nxt[g] = 1'b0;
              phase_nxt  = PH_BDARK;
              wait_nxt   = tps_r;
            end
            PH_BDARK: begin
              lit_nxt[g] = 1'b1;
              wait_nxt   = quarter;
              if (pulses_r <= lbcs_pkg::COUNT_W'(1)) begin
                pulses_nxt = '0;
                phase_nxt  = PH_DONE;
              end else begin
                pulses_nxt = pulses_r - lbcs_pkg::COUNT_W'(1);
                phase_nxt  = PH_BLIT;
              end
            end
            PH_BLIT: begin
              lit_nxt[g] = 1'b0;
              phase_nxt  = PH_BDARK;
              wait_nxt   = quarter;
            end
            default: begin
              lit_nxt[g]    = 1'b0;
              active_nxt[g] = 1'b0;
            end
          endcase
        end
      end
    end

    // Per-LED state registers.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        phase_r     <= PH_START;
        wait_r      <= '0;
        pulses_r    <= '0;
        code_r      <= '0;
        lit_r[g]    <= 1'b0;
        active_r[g] <= 1'b0;
      end else begin
        phase_r     <= phase_nxt;
        wait_r      <= wait_nxt;
        pulses_r    <= pulses_nxt;
        code_r      <= code_nxt;
        lit_r[g]    <= lit_nxt[g];
        active_r[g] <= active_nxt[g];
      end
    end
  end

  // Only the first two LEDs are visible in the result masks.
  assign lit_pad    = PadW'(lit_nxt);
  assign active_pad = PadW'(active_nxt);

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      levels_r <= lit_pad[lbcs_pkg::OUT_W-1:0];
      busy_r   <= active_pad[lbcs_pkg::OUT_W-1:0];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.led_levels = levels_r;
  assign out_ch.busy_mask  = busy_r;

`ifndef SYNTHESIS
  // A taken request always leaves a result waiting in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_ch.valid)
    else $error("no result after an accepted request");

  // A set command with count zero on LED 0 reports that LED as idle.
  a_stop_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.cmd == lbcs_pkg::CMD_SET && in_ch.led_index == '0 &&
    in_ch.blink_count == '0 |=> !out_ch.busy_mask[0])
    else $error("stopped LED still reported busy");

  // A tick with no sequence running leaves the reported levels unchanged.
  a_idle_tick_levels: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_tick && active_r == '0 |=>
    out_ch.led_levels == $past(lit_pad[lbcs_pkg::OUT_W-1:0]) && out_ch.busy_mask == '0)
    else $error("idle tick changed LED levels");
`endif

endmodule

>>> tb/sv/led_blink_code_sequencer_core_tb.sv
// Self-checking testbench for the LED blink-code sequencer core.
`timescale 1ns / 100ps

module led_blink_code_sequencer_core_tb;

  localparam int unsigned LED_COUNT   = 2;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_LIMIT = 2000;

  // Sequence steps of one LED; unused codes behave like the done step.
  typedef enum logic [2:0] {
    SEQ_START       = 3'd0,
    SEQ_SILENT      = 3'd1,
    SEQ_FIRST_LIGHT = 3'd2,
    SEQ_BLINK_DARK  = 3'd3,
    SEQ_BLINK_LIT   = 3'd4,
    SEQ_DONE        = 3'd5
  } seq_phase_t;

  typedef struct packed {
    logic [lbcs_pkg::OUT_W-1:0] led_levels;
    logic [lbcs_pkg::OUT_W-1:0] busy_mask;
  } led_status_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [lbcs_pkg::TPS_W-1:0] cfg_wdata;

  lbcs_in_if  in_ch ();
  lbcs_out_if out_ch ();

  led_blink_code_sequencer_core #(
    .LED_COUNT(LED_COUNT)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Predicted sequencer state, one entry per LED.
  logic [lbcs_pkg::TPS_W-1:0]   ticks_per_sec;
  seq_phase_t                   led_phase  [LED_COUNT];
  logic [lbcs_pkg::TPS_W-1:0]   led_wait   [LED_COUNT];
  logic [lbcs_pkg::COUNT_W-1:0] led_pulses [LED_COUNT];
  logic [lbcs_pkg::COUNT_W-1:0] led_code   [LED_COUNT];
  logic                         led_lit    [LED_COUNT];
  logic                         led_active [LED_COUNT];

  led_status_t expected_status_q[$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned src_gap_pct;
  int unsigned sink_gap_pct;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Applies one request to the predicted state and returns the status it reports.
  function automatic led_status_t apply_request(input logic [lbcs_pkg::CMD_W-1:0] cmd,
                                                input logic [lbcs_pkg::IDX_W-1:0] led_index,
                                                input logic [lbcs_pkg::COUNT_W-1:0] blink_count);
    led_status_t status;
    status = '0;
    if (cmd == lbcs_pkg::CMD_SET) begin
      if (led_index < LED_COUNT) begin
        led_code[led_index]   = blink_count;
        led_phase[led_index]  = SEQ_START;
        led_wait[led_index]   = '0;
        led_active[led_index] = (blink_count != 0);
      end
    end else begin
      for (int i = 0; i < LED_COUNT; i++) begin
        if (led_active[i]) begin
          if (led_wait[i] > 1) begin
            led_wait[i] = led_wait[i] - 1'b1;
          end else begin
            case (led_phase[i])
              SEQ_START: begin
                led_lit[i]    = 1'b0;
                led_phase[i]  = SEQ_SILENT;
                led_wait[i]   = ticks_per_sec;
                led_pulses[i] = led_code[i];
              end
              SEQ_SILENT: begin
                led_lit[i]   = 1'b1;
                led_phase[i] = SEQ_FIRST_LIGHT;
                led_wait[i]  = ticks_per_sec;
              end
              SEQ_FIRST_LIGHT: begin
                led_lit[i]   = 1'b0;
                led_phase[i] = SEQ_BLINK_DARK;
                led_wait[i]  = ticks_per_sec;
              end
              SEQ_BLINK_DARK: begin
                led_lit[i]  = 1'b1;
                led_wait[i] = ticks_per_sec >> 2;
                // The last pulse, or none left, ends the sequence after this light.
                if (led_pulses[i] <= 1) begin
                  led_pulses[i] = '0;
                  led_phase[i]  = SEQ_DONE;
                end else begin
                  led_pulses[i] = led_pulses[i] - 1'b1;
                  led_phase[i]  = SEQ_BLINK_LIT;
                end
              end
              SEQ_BLINK_LIT: begin
                led_lit[i]   = 1'b0;
                led_phase[i] = SEQ_BLINK_DARK;
                led_wait[i]  = ticks_per_sec >> 2;
              end
              default: begin
                led_lit[i]    = 1'b0;
                led_active[i] = 1'b0;
              end
            endcase
          end
        end
      end
    end
    for (int i = 0; i < LED_COUNT && i < lbcs_pkg::OUT_W; i++) begin
      status.led_levels[i] = led_lit[i];
      status.busy_mask[i]  = led_active[i];
    end
    return status;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR at %0t: %s: got %0h, expected %0h", $time, what, got, want);
    error_count++;
  endtask

  // Sends one request, optionally after a random idle gap, and records its prediction.
  // Called right after a rising edge; returns right after the accepting edge.
  task automatic send_request(input logic [lbcs_pkg::CMD_W-1:0] cmd,
                              input logic [lbcs_pkg::IDX_W-1:0] led_index,
                              input logic [lbcs_pkg::COUNT_W-1:0] blink_count);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.led_index   <= led_index;
    in_ch.blink_count <= blink_count;
    do @(posedge clk); while (!in_ch.ready);
    expected_status_q.push_back(apply_request(cmd, led_index, blink_count));
  endtask

  task automatic send_tick();
    send_request(lbcs_pkg::CMD_TICK, lbcs_pkg::IDX_W'($urandom_range(0, 1)),
                 lbcs_pkg::COUNT_W'($urandom_range(0, 15)));
  endtask

  // Stops requests, lets every result arrive, then writes the tick rate.
  task automatic write_ticks_per_second(input logic [lbcs_pkg::TPS_W-1:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_status_q.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    ticks_per_sec = value;
    cfg_we <= 1'b0;
  endtask

  // A few requests at the reset tick rate, leaving a long wait running.
  task automatic test_reset_rate();
    send_request(lbcs_pkg::CMD_SET, 1'b1, 4'd2);
    repeat (3) send_tick();
    send_request(lbcs_pkg::CMD_SET, 1'b0, 4'd0);
  endtask

  // A full short sequence at tick rate 4, extreme counts and a stop part-way through a sequence.
  task automatic test_directed();
    write_ticks_per_second(16'd4);
    send_request(lbcs_pkg::CMD_SET, 1'b0, 4'd15);
    send_request(lbcs_pkg::CMD_SET, 1'b1, 4'd1);
    repeat (16) send_tick();
    send_request(lbcs_pkg::CMD_SET, 1'b0, 4'd0);
    send_tick();
  endtask

  // Mostly ticks with occasional set commands, so sequences run to completion.
  task automatic test_random_traffic(input logic [lbcs_pkg::TPS_W-1:0] rate,
                                     input int unsigned src_pct,
                                     input int unsigned sink_pct,
                                     input int unsigned n_requests);
    write_ticks_per_second(rate);
    src_gap_pct  = src_pct;
    sink_gap_pct = sink_pct;
    repeat (n_requests) begin
      if ($urandom_range(0, 99) < 4)
        send_request(lbcs_pkg::CMD_SET, lbcs_pkg::IDX_W'($urandom_range(0, 1)),
                     lbcs_pkg::COUNT_W'($urandom_range(0, 15)));
      else
        send_tick();
    end
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk) begin
    led_status_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_status_q.size() == 0) begin
        report_mismatch("result with no request pending", {out_ch.led_levels, out_ch.busy_mask},
                        0);
      end else begin
        want = expected_status_q.pop_front();
        if (out_ch.led_levels !== want.led_levels)
          report_mismatch("led_levels", out_ch.led_levels, want.led_levels);
        if (out_ch.busy_mask !== want.busy_mask)
          report_mismatch("busy_mask", out_ch.busy_mask, want.busy_mask);
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= sink_gap_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** led_blink_code_sequencer_core: FAILED **");
      $finish;
    end
  end

  initial begin
    int unsigned drain_cycles;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = lbcs_pkg::CMD_TICK;
    in_ch.led_index   = '0;
    in_ch.blink_count = '0;
    out_ch.ready      = 1'b0;
    error_count       = 0;
    cycle_count       = 0;
    src_gap_pct       = 13;
    sink_gap_pct      = 88;
    ticks_per_sec     = lbcs_pkg::TPS_RESET;
    for (int i = 0; i < LED_COUNT; i++) begin
      led_phase[i]  = SEQ_START;
      led_wait[i]   = '0;
      led_pulses[i] = '0;
      led_code[i]   = '0;
      led_lit[i]    = 1'b0;
      led_active[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_rate();
    test_directed();
    // Sender idles rarely, receiver mostly stalls.
    test_random_traffic(16'd5, 13, 88, 150);
    test_random_traffic(16'd0, 13, 88, 60);
    // Sender mostly idles, receiver rarely stalls.
    test_random_traffic(16'd3, 88, 13, 80);
    test_random_traffic(lbcs_pkg::TPS_W'($urandom_range(6, 12)), 88, 13, 150);
    // No idling on either side.
    test_random_traffic(16'hFFFF, 0, 0, 40);
    test_random_traffic(16'd4, 0, 0, 220);

    // Drain the remaining results.
    in_ch.valid <= 1'b0;
    drain_cycles = 0;
    while (expected_status_q.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (4) @(posedge clk);
    if (error_count == 0 && expected_status_q.size() == 0) begin
      $display("** led_blink_code_sequencer_core: PASSED **");
    end else begin
      $display("** led_blink_code_sequencer_core: FAILED **");
    end
    $finish;
  end

endmodule
